// File: rtl/lnr_pkg.sv
// ---------------------------------------------------------------------------
// lnr_pkg - shared definitions for the layer normalization row block
// Widths, fixed-point constants, state codes and unit request/response types.
// ---------------------------------------------------------------------------
package lnr_pkg;

	localparam int MAX_FEATURES = 64;
	localparam int DATA_WIDTH   = 16;
	localparam int AW           = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int CW           = $clog2(MAX_FEATURES + 1);
	localparam int EPS_W        = 16;

	// row sum, deviation n*x - S and its magnitude
	localparam int SUM_W  = DATA_WIDTH + CW;
	localparam int DEV_W  = DATA_WIDTH + CW + 1;
	localparam int MAG_W  = DEV_W - 1;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int SSQ_W  = SQ_W + CW;
	localparam int N2_W   = 2 * CW;
	localparam int N3_W   = 3 * CW;

	// shared divider
	localparam int NUM_W  = SSQ_W;
	localparam int DEN_W  = 32;
	localparam int IT_W   = $clog2(NUM_W + 1);

	// variance, root and reciprocal
	localparam int V_W    = 32;
	localparam int RAD_W  = 2 * V_W;
	localparam int ROOT_W = V_W;
	localparam int INV_W  = 33;
	localparam int INV_LO = 17;
	localparam int INV_ITERS = 49;

	// per-element scaling
	localparam int P_W    = MAG_W + INV_W;
	localparam int T_W    = P_W + 1 - 24;
	localparam int NORM_W = 26;
	localparam int PROD_W = NORM_W + DATA_WIDTH;
	localparam int Y_W    = PROD_W + 1;

	localparam logic signed [DATA_WIDTH-1:0] Q88_ONE = DATA_WIDTH'(256);
	localparam logic signed [Y_W-1:0] SAT_HI = Y_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
	localparam logic signed [Y_W-1:0] SAT_LO = -SAT_HI - Y_W'(1);

	// configuration register indexes
	localparam logic [1:0] CFG_EPSILON    = 2'd0;
	localparam logic [1:0] CFG_USE_WEIGHT = 2'd1;
	localparam logic [1:0] CFG_USE_BIAS   = 2'd2;

	typedef enum logic [12:0] {
		S_LOAD  = 13'b0000000000001,
		S_VAR   = 13'b0000000000010,
		S_VDIV  = 13'b0000000000100,
		S_SQRT  = 13'b0000000001000,
		S_IDIV  = 13'b0000000010000,
		S_RD    = 13'b0000000100000,
		S_DEV   = 13'b0000001000000,
		S_MLO   = 13'b0000010000000,
		S_MHI   = 13'b0000100000000,
		S_EDIV  = 13'b0001000000000,
		S_EWAIT = 13'b0010000000000,
		S_SCALE = 13'b0100000000000,
		S_EMIT  = 13'b1000000000000
	} state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic [IT_W-1:0]  iters;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic             start;
		logic [RAD_W-1:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [ROOT_W-1:0] root;
	} sqrt_rsp_t;

	// deviation of one element scaled by n: n*x - S
	function automatic logic signed [DEV_W-1:0] dev_of(
		input logic [CW-1:0]                n,
		input logic signed [DATA_WIDTH-1:0] x,
		input logic signed [SUM_W-1:0]      s
	);
		logic signed [DEV_W-1:0] n_w;
		logic signed [DEV_W-1:0] x_w;
		logic signed [DEV_W-1:0] s_w;
		n_w = DEV_W'({1'b0, n});
		x_w = DEV_W'(x);
		s_w = DEV_W'(s);
		return n_w * x_w - s_w;
	endfunction

	function automatic logic [MAG_W-1:0] mag_of(input logic signed [DEV_W-1:0] d);
		logic signed [DEV_W-1:0] a;
		a = d[DEV_W-1] ? -d : d;
		return a[MAG_W-1:0];
	endfunction

endpackage

// File: rtl/layer_normalization_row.sv
// ---------------------------------------------------------------------------
// layer_normalization_row - layer normalization of one feature row
// Stores a row, then emits (x-mean)*inv_std*weight+bias per element, Q8.8.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one element beat per cycle,
//   while in_stall is low, with its weight and bias; row_end flags the
//   last one. Elements past MAX_FEATURES are dropped and the row's results
//   carry row_overflow. After row_end, in_stall stays high while the row
//   is processed: a variance pass, a divide, a square root and a reciprocal
//   divide on the shared serial divider and root unit. Each element is then
//   read, multiplied by the reciprocal, divided by n, weighted and biased,
//   and goes out as one result beat.
//   The output register holds a beat while out_stall is high; the next
//   element waits for it. After the last result the block takes the next
//   row at once, even while that beat still waits.
//   Configuration (cfg_valid/cfg_ready, always ready) is written while idle;
//   the block does not enforce this. Reset clears counts, flags, state and
//   config, not datapath or row storage; only current-row entries are read.
// ---------------------------------------------------------------------------
module layer_normalization_row (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [lnr_pkg::DATA_WIDTH-1:0] sample_value,
	input  logic signed [lnr_pkg::DATA_WIDTH-1:0] gain_value,
	input  logic signed [lnr_pkg::DATA_WIDTH-1:0] offset_value,
	input  logic                                  row_end,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [lnr_pkg::DATA_WIDTH-1:0] norm_value,
	output logic                                  last_of_row,
	output logic                                  row_overflow,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [1:0]                            cfg_index,
	input  logic [lnr_pkg::EPS_W-1:0]             cfg_data
);

	localparam int DW = lnr_pkg::DATA_WIDTH;
	localparam int RAM_W = 3 * DW;
	localparam int VS_W = lnr_pkg::NUM_W + 1;

	lnr_pkg::state_t state_q;

	logic [lnr_pkg::EPS_W-1:0] eps_q;
	logic                      use_w_q;
	logic                      use_b_q;

	logic [lnr_pkg::CW-1:0]          count_q;
	logic signed [lnr_pkg::SUM_W-1:0] sum_q;
	logic                            ovf_q;
	logic [lnr_pkg::CW-1:0]          idx_q;
	logic [lnr_pkg::CW-1:0]          acc_cnt_q;
	logic [lnr_pkg::SSQ_W-1:0]       sumsq_q;
	logic [lnr_pkg::N2_W-1:0]        n2_q;
	logic [lnr_pkg::INV_W-1:0]       inv_q;

	logic                            rd_v_s1;
	logic                            v_s2;
	logic                            v_s3;
	logic [lnr_pkg::MAG_W-1:0]       mag_s2;
	logic [lnr_pkg::SQ_W-1:0]        sq_s3;

	logic                            neg_q;
	logic [lnr_pkg::MAG_W-1:0]       mag_q;
	logic signed [DW-1:0]            w_q;
	logic signed [DW-1:0]            b_q;
	logic [lnr_pkg::P_W-1:0]         plo_q;
	logic [lnr_pkg::P_W-1:0]         p_q;
	logic signed [lnr_pkg::PROD_W-1:0] prod_q;

	logic                            out_valid_q;
	logic signed [DW-1:0]            out_norm_q;
	logic                            out_last_q;
	logic                            out_ovf_q;

	logic                            in_acc;
	logic                            out_free;
	logic                            ram_we;
	logic                            ram_re;
	logic [lnr_pkg::AW-1:0]          ram_raddr;
	logic [RAM_W-1:0]                ram_rdata;
	logic signed [DW-1:0]            rd_x;
	logic signed [DW-1:0]            rd_g;
	logic signed [DW-1:0]            rd_b;
	logic signed [lnr_pkg::DEV_W-1:0] rd_dev;
	logic [lnr_pkg::N3_W-1:0]        n3;
	logic [VS_W-1:0]                 v_sum;
	logic [lnr_pkg::V_W-1:0]         v_val;
	logic [lnr_pkg::P_W:0]           t_sum;
	logic [lnr_pkg::T_W-1:0]         t_val;
	logic signed [lnr_pkg::NORM_W-1:0] norm_c;
	logic [lnr_pkg::PROD_W-1:0]      prod_mag;
	logic [lnr_pkg::PROD_W-1:0]      rq_mag;
	logic signed [lnr_pkg::Y_W-1:0]  y_w;
	logic signed [DW-1:0]            y_sat;
	logic                            is_last;

	lnr_pkg::div_req_t  div_req;
	lnr_pkg::div_rsp_t  div_rsp;
	lnr_pkg::sqrt_req_t sq_req;
	lnr_pkg::sqrt_rsp_t sq_rsp;

	assign in_stall  = (state_q != lnr_pkg::S_LOAD);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign ram_we    = in_acc && (count_q < lnr_pkg::CW'(lnr_pkg::MAX_FEATURES));
	assign is_last   = (idx_q == count_q - lnr_pkg::CW'(1));

	// row storage: {offset, gain, sample}
	lnr_ram #(
		.WIDTH(RAM_W),
		.DEPTH(lnr_pkg::MAX_FEATURES)
	) u_row_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[lnr_pkg::AW-1:0]),
		.wdata({offset_value, gain_value, sample_value}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	lnr_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	lnr_isqrt u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (sq_req),
		.rsp   (sq_rsp)
	);

	// read port and shared arithmetic
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = idx_q[lnr_pkg::AW-1:0];
		if (state_q == lnr_pkg::S_VAR && idx_q < count_q) begin
			ram_re = 1'b1;
		end
		if (state_q == lnr_pkg::S_RD) begin
			ram_re = 1'b1;
		end
		rd_x   = ram_rdata[DW-1:0];
		rd_g   = ram_rdata[2*DW-1:DW];
		rd_b   = ram_rdata[3*DW-1:2*DW];
		rd_dev = lnr_pkg::dev_of(count_q, rd_x, sum_q);
		n3     = lnr_pkg::N3_W'(n2_q) * lnr_pkg::N3_W'(count_q);

		// variance plus epsilon, saturated
		v_sum = VS_W'(div_rsp.quot) + VS_W'(eps_q);
		if (v_sum[VS_W-1:lnr_pkg::V_W] != '0) begin
			v_val = '1;
		end else begin
			v_val = v_sum[lnr_pkg::V_W-1:0];
		end

		// |D|*inv rounded at 2^24*n: add n*2^23, drop 24 bits, then divide by n
		t_sum = (lnr_pkg::P_W + 1)'(p_q) + ((lnr_pkg::P_W + 1)'(count_q) << 23);
		t_val = t_sum[lnr_pkg::P_W:24];

		// signed normalized term, clamped where the result saturates anyway
		if (div_rsp.quot > lnr_pkg::NUM_W'(1 << 24)) begin
			norm_c = lnr_pkg::NORM_W'(1 << 24);
		end else begin
			norm_c = lnr_pkg::NORM_W'(div_rsp.quot);
		end
		if (neg_q) begin
			norm_c = -norm_c;
		end

		// round product by 256 with ties away from zero, add bias, saturate
		prod_mag = prod_q[lnr_pkg::PROD_W-1] ? lnr_pkg::PROD_W'(-prod_q)
			: lnr_pkg::PROD_W'(prod_q);
		rq_mag = (prod_mag + lnr_pkg::PROD_W'(128)) >> 8;
		y_w = lnr_pkg::Y_W'(signed'({1'b0, rq_mag}));
		if (prod_q[lnr_pkg::PROD_W-1]) begin
			y_w = -y_w;
		end
		y_w = y_w + lnr_pkg::Y_W'(b_q);
		if (y_w > lnr_pkg::SAT_HI) begin
			y_sat = DW'(lnr_pkg::SAT_HI);
		end else if (y_w < lnr_pkg::SAT_LO) begin
			y_sat = DW'(lnr_pkg::SAT_LO);
		end else begin
			y_sat = y_w[DW-1:0];
		end
	end

	// requests to the divider and the root unit
	always_comb begin
		div_req = '0;
		sq_req  = '0;
		case (state_q)
			lnr_pkg::S_VAR: begin
				if (acc_cnt_q == count_q) begin
					div_req.start = 1'b1;
					div_req.num   = sumsq_q;
					div_req.den   = lnr_pkg::DEN_W'(n3);
					div_req.iters = lnr_pkg::IT_W'(lnr_pkg::NUM_W);
				end
			end
			lnr_pkg::S_VDIV: begin
				if (div_rsp.done && v_val != '0) begin
					sq_req.start    = 1'b1;
					sq_req.radicand = {v_val, {lnr_pkg::V_W{1'b0}}};
				end
			end
			lnr_pkg::S_SQRT: begin
				if (sq_rsp.done) begin
					div_req.start = 1'b1;
					div_req.num   = lnr_pkg::NUM_W'(1) << (lnr_pkg::NUM_W - 1);
					div_req.den   = lnr_pkg::DEN_W'(sq_rsp.root);
					div_req.iters = lnr_pkg::IT_W'(lnr_pkg::INV_ITERS);
				end
			end
			lnr_pkg::S_EDIV: begin
				div_req.start = 1'b1;
				div_req.num   = lnr_pkg::NUM_W'(t_val) << (lnr_pkg::NUM_W - lnr_pkg::T_W);
				div_req.den   = lnr_pkg::DEN_W'(count_q);
				div_req.iters = lnr_pkg::IT_W'(lnr_pkg::T_W);
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q   <= lnr_pkg::EPS_W'(1);
			use_w_q <= 1'b1;
			use_b_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lnr_pkg::CFG_EPSILON:    eps_q   <= cfg_data;
				lnr_pkg::CFG_USE_WEIGHT: use_w_q <= cfg_data[0];
				lnr_pkg::CFG_USE_BIAS:   use_b_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// output beat valid: set on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == lnr_pkg::S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer and row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lnr_pkg::S_LOAD;
			count_q     <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			acc_cnt_q   <= '0;
			sumsq_q     <= '0;
			rd_v_s1     <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == lnr_pkg::S_VAR) && ram_re;
			v_s2    <= rd_v_s1;
			v_s3    <= v_s2;
			case (state_q)
				lnr_pkg::S_LOAD: begin
					if (in_acc) begin
						if (ram_we) begin
							count_q <= count_q + lnr_pkg::CW'(1);
							sum_q   <= sum_q + lnr_pkg::SUM_W'(sample_value);
						end else begin
							ovf_q <= 1'b1;
						end
						if (row_end) begin
							idx_q     <= '0;
							acc_cnt_q <= '0;
							sumsq_q   <= '0;
							state_q   <= lnr_pkg::S_VAR;
						end
					end
				end
				lnr_pkg::S_VAR: begin
					if (ram_re) begin
						idx_q <= idx_q + lnr_pkg::CW'(1);
					end
					if (v_s3) begin
						sumsq_q   <= sumsq_q + lnr_pkg::SSQ_W'(sq_s3);
						acc_cnt_q <= acc_cnt_q + lnr_pkg::CW'(1);
					end
					if (acc_cnt_q == count_q) begin
						state_q <= lnr_pkg::S_VDIV;
					end
				end
				lnr_pkg::S_VDIV: begin
					if (div_rsp.done) begin
						idx_q <= '0;
						if (v_val != '0) begin
							state_q <= lnr_pkg::S_SQRT;
						end else begin
							inv_q   <= '0;
							state_q <= lnr_pkg::S_RD;
						end
					end
				end
				lnr_pkg::S_SQRT: begin
					if (sq_rsp.done) begin
						state_q <= lnr_pkg::S_IDIV;
					end
				end
				lnr_pkg::S_IDIV: begin
					if (div_rsp.done) begin
						inv_q   <= div_rsp.quot[lnr_pkg::INV_W-1:0];
						state_q <= lnr_pkg::S_RD;
					end
				end
				lnr_pkg::S_RD:    state_q <= lnr_pkg::S_DEV;
				lnr_pkg::S_DEV:   state_q <= lnr_pkg::S_MLO;
				lnr_pkg::S_MLO:   state_q <= lnr_pkg::S_MHI;
				lnr_pkg::S_MHI:   state_q <= lnr_pkg::S_EDIV;
				lnr_pkg::S_EDIV:  state_q <= lnr_pkg::S_EWAIT;
				lnr_pkg::S_EWAIT: begin
					if (div_rsp.done) begin
						state_q <= lnr_pkg::S_SCALE;
					end
				end
				lnr_pkg::S_SCALE: state_q <= lnr_pkg::S_EMIT;
				lnr_pkg::S_EMIT: begin
					if (out_free) begin
						if (is_last) begin
							count_q <= '0;
							sum_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= lnr_pkg::S_LOAD;
						end else begin
							idx_q   <= idx_q + lnr_pkg::CW'(1);
							state_q <= lnr_pkg::S_RD;
						end
					end
				end
				default: state_q <= lnr_pkg::S_LOAD;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		n2_q   <= lnr_pkg::N2_W'(count_q) * lnr_pkg::N2_W'(count_q);
		mag_s2 <= lnr_pkg::mag_of(rd_dev);
		sq_s3  <= lnr_pkg::SQ_W'(mag_s2) * lnr_pkg::SQ_W'(mag_s2);
		if (state_q == lnr_pkg::S_DEV) begin
			neg_q <= rd_dev[lnr_pkg::DEV_W-1];
			mag_q <= lnr_pkg::mag_of(rd_dev);
			w_q   <= use_w_q ? rd_g : lnr_pkg::Q88_ONE;
			b_q   <= use_b_q ? rd_b : '0;
		end
		if (state_q == lnr_pkg::S_MLO) begin
			plo_q <= lnr_pkg::P_W'(mag_q) * lnr_pkg::P_W'(inv_q[lnr_pkg::INV_LO-1:0]);
		end
		if (state_q == lnr_pkg::S_MHI) begin
			p_q <= plo_q + ((lnr_pkg::P_W'(mag_q)
				* lnr_pkg::P_W'(inv_q[lnr_pkg::INV_W-1:lnr_pkg::INV_LO])) << lnr_pkg::INV_LO);
		end
		if (state_q == lnr_pkg::S_SCALE) begin
			prod_q <= lnr_pkg::PROD_W'(norm_c) * lnr_pkg::PROD_W'(w_q);
		end
		if (state_q == lnr_pkg::S_EMIT && out_free) begin
			out_norm_q <= y_sat;
			out_last_q <= is_last;
			out_ovf_q  <= ovf_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign norm_value   = out_norm_q;
	assign last_of_row  = out_last_q;
	assign row_overflow = out_ovf_q;

	// stored count never passes the row capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lnr_pkg::CW'(lnr_pkg::MAX_FEATURES))
		else $error("element count above capacity");

	// the divider is never restarted while it is working
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// a row end beat starts the variance pass
	a_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && row_end) |=> state_q == lnr_pkg::S_VAR)
		else $error("row end did not start processing");

endmodule

// File: rtl/lnr_ram.sv
// ---------------------------------------------------------------------------
// lnr_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module lnr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/lnr_div.sv
// ---------------------------------------------------------------------------
// lnr_div - restoring divider, one quotient bit per cycle
// The numerator is top-aligned by the caller; iters bits are consumed.
// ---------------------------------------------------------------------------
module lnr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lnr_pkg::div_req_t req,
	output lnr_pkg::div_rsp_t rsp
);

	logic [lnr_pkg::NUM_W-1:0] num_q;
	logic [lnr_pkg::NUM_W-1:0] quo_q;
	logic [lnr_pkg::DEN_W-1:0] den_q;
	logic [lnr_pkg::DEN_W:0]   rem_q;
	logic [lnr_pkg::IT_W-1:0]  cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [lnr_pkg::DEN_W:0]   rem_sh;
	logic                      fits;

	// shift one numerator bit into the remainder and trial subtract
	always_comb begin
		rem_sh = {rem_q[lnr_pkg::DEN_W-1:0], num_q[lnr_pkg::NUM_W-1]};
		fits   = rem_sh >= {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - lnr_pkg::IT_W'(1);
				if (cnt_q == lnr_pkg::IT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[lnr_pkg::NUM_W-2:0], 1'b0};
			rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[lnr_pkg::NUM_W-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// File: rtl/lnr_isqrt.sv
// ---------------------------------------------------------------------------
// lnr_isqrt - integer square root, one root bit per cycle
// Digit-by-digit method over two radicand bits a step.
// ---------------------------------------------------------------------------
module lnr_isqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  lnr_pkg::sqrt_req_t req,
	output lnr_pkg::sqrt_rsp_t rsp
);

	localparam int RW = lnr_pkg::ROOT_W + 2;
	localparam int KW = $clog2(lnr_pkg::ROOT_W + 1);

	logic [lnr_pkg::RAD_W-1:0]  rad_q;
	logic [RW-1:0]              rem_q;
	logic [lnr_pkg::ROOT_W-1:0] root_q;
	logic [KW-1:0]              cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [RW-1:0]              rem_sh;
	logic [RW-1:0]              trial;
	logic                       fits;

	// bring down two bits and try root*4+1
	always_comb begin
		rem_sh = {rem_q[RW-3:0], rad_q[lnr_pkg::RAD_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		fits   = rem_sh >= trial;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= KW'(lnr_pkg::ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - KW'(1);
				if (cnt_q == KW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[lnr_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= fits ? rem_sh - trial : rem_sh;
			root_q <= {root_q[lnr_pkg::ROOT_W-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule
